FILE: rtl/ets_pkg.sv
// Shared constants, types and the month length table for the epoch
// seconds to calendar converter. No dependencies.
`default_nettype none

package ets_pkg;

  // Field widths
  localparam int unsigned EpochW  = 32;
  localparam int unsigned BiasW   = 12;
  localparam int unsigned YearW   = 8;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;

  // Serial divider sizing
  localparam int unsigned RemW    = 17;  // holds any remainder below SecPerDay
  localparam int unsigned StepW   = 6;   // up to EpochW steps
  localparam int unsigned DaysW   = 16;  // whole days fit below 2^16
  localparam int unsigned MinDayW = 11;  // minute of day below 1440

  // Divisors
  localparam logic [RemW-1:0] SecPerDay = RemW'(86400);
  localparam logic [RemW-1:0] SecPerMin = RemW'(60);
  localparam logic [RemW-1:0] MinPerHr  = RemW'(60);

  // Calendar constants, years counted from 1900
  localparam logic [YearW-1:0] YearEpoch   = YearW'(70);
  localparam logic [YearW-1:0] YearNoLeap  = YearW'(200);   // 2100 is a common year
  localparam logic [YearW-1:0] YearSkip    = YearW'(198);   // block 2098..2101
  localparam logic [DaysW-1:0] DaysYear    = DaysW'(365);
  localparam logic [DaysW-1:0] DaysLeap    = DaysW'(366);
  localparam logic [DaysW-1:0] DaysBlock   = DaysW'(1461);
  localparam logic [DaysW-1:0] DaysBlockNl = DaysW'(1460);
  localparam logic [MonthW-1:0] MonthFeb   = MonthW'(1);
  localparam logic [MonthW-1:0] MonthDec   = MonthW'(11);

  // Divider control and status
  typedef struct packed {
    logic              start;
    logic [EpochW-1:0] dividend;
    logic [RemW-1:0]   divisor;
    logic [StepW-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [EpochW-1:0] quotient;
    logic [RemW-1:0]   remainder;
  } div_rsp_t;

  // Calendar walker control and status
  typedef struct packed {
    logic             start;
    logic [DaysW-1:0] days;
  } cal_req_t;

  typedef struct packed {
    logic              valid;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } cal_rsp_t;

  // Days in a common-year month, month 0 is January
  function automatic logic [DaysW-1:0] month_days(logic [MonthW-1:0] m);
    logic [DaysW-1:0] len;
    case (m) inside
      MonthFeb:                  len = DaysW'(28);
      4'd3, 4'd5, 4'd8, 4'd10:   len = DaysW'(30);
      default:                   len = DaysW'(31);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ets_stream_if.sv
// Valid/ready channels of the epoch seconds to calendar converter.
// Depends on ets_pkg for the field widths.
`default_nettype none

interface ets_in_if import ets_pkg::*;;
  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ets_out_if import ets_pkg::*;;
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year_since_1900;
  logic [MonthW-1:0] month_number;
  logic [DayW-1:0]   day_of_month;
  logic [HourW-1:0]  hour_of_day;
  logic [MinW-1:0]   minute_of_hour;
  logic [SecW-1:0]   second_of_minute;

  modport source (output valid, output year_since_1900, output month_number,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, input ready);
  modport sink   (input valid, input year_since_1900, input month_number,
                  input day_of_month, input hour_of_day, input minute_of_hour,
                  input second_of_minute, output ready);
endinterface

`default_nettype wire

FILE: rtl/ets_serdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, dividend
// left-aligned in a shift register. Depends on ets_pkg.
`default_nettype none

module ets_serdiv import ets_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  div_req_t  req_i,
  output div_rsp_t  rsp_o
);

  logic [EpochW-1:0] sh_q, sh_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [RemW-1:0]   div_q;
  logic [StepW-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [RemW:0]     trial, diff;
  logic              fits;

  // Trial subtract of the divisor from the partial remainder
  assign trial = {rem_q, sh_q[EpochW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    sh_d  = sh_q;
    rem_d = rem_q;
    if (req_i.start) begin
      sh_d  = req_i.dividend;
      rem_d = '0;
    end else if (busy_q) begin
      sh_d  = {sh_q[EpochW-2:0], fits};
      rem_d = fits ? diff[RemW-1:0] : trial[RemW-1:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      div_q <= req_i.divisor;
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == StepW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = sh_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

FILE: rtl/ets_calwalk.sv
// Year and month walk: turns a day count since 1 January 1970 into year,
// month and day, one subtraction per cycle. Depends on ets_pkg.
`default_nettype none

module ets_calwalk import ets_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cal_req_t  req_i,
  output cal_rsp_t  rsp_o
);

  typedef enum logic [2:0] {
    CW_IDLE  = 3'b001,
    CW_YEAR  = 3'b010,
    CW_MONTH = 3'b100
  } cw_state_e;

  cw_state_e         state_q, state_d;
  logic              block_q, block_d;
  logic              valid_q, valid_d;
  logic [DaysW-1:0]  days_q, days_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;

  logic              leap;
  logic [DaysW-1:0]  ylen, mlen;

  // Leap years in range: divisible by four, except 2100
  assign leap = (year_q[1:0] == 2'b00) && (year_q != YearNoLeap);

  // Step length: a four-year block while it fits, else one year
  always_comb begin
    if (block_q) begin
      ylen = (year_q == YearSkip) ? DaysBlockNl : DaysBlock;
    end else begin
      ylen = leap ? DaysLeap : DaysYear;
    end
    mlen = month_days(month_q) + DaysW'(((month_q == MonthFeb) && leap) ? 1 : 0);
  end

  always_comb begin
    state_d = state_q;
    block_d = block_q;
    valid_d = valid_q;
    days_d  = days_q;
    year_d  = year_q;
    month_d = month_q;
    unique case (state_q)
      CW_IDLE: begin
        if (req_i.start) begin
          state_d = CW_YEAR;
          block_d = 1'b1;
          valid_d = 1'b0;
          days_d  = req_i.days;
          year_d  = YearEpoch;
          month_d = '0;
        end
      end
      CW_YEAR: begin
        if (days_q >= ylen) begin
          days_d = days_q - ylen;
          year_d = year_q + (block_q ? YearW'(4) : YearW'(1));
        end else if (block_q) begin
          block_d = 1'b0;
        end else begin
          state_d = CW_MONTH;
        end
      end
      CW_MONTH: begin
        if ((days_q < mlen) || (month_q == MonthDec)) begin
          state_d = CW_IDLE;
          valid_d = 1'b1;
        end else begin
          days_d  = days_q - mlen;
          month_d = month_q + MonthW'(1);
        end
      end
      default: begin
        state_d = CW_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CW_IDLE;
      valid_q <= 1'b0;
      block_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      block_q <= block_d;
    end
  end

  // Working values
  always_ff @(posedge clk_i) begin
    days_q  <= days_d;
    year_q  <= year_d;
    month_q <= month_d;
  end

  assign rsp_o.valid = valid_q;
  assign rsp_o.year  = year_q;
  assign rsp_o.month = month_q + MonthW'(1);
  assign rsp_o.day   = days_q[DayW-1:0] + DayW'(1);

endmodule

`default_nettype wire

FILE: rtl/epoch_seconds_to_calendar.sv
// Epoch seconds to calendar converter.
//
// Input channel in_i carries an unsigned 32-bit count of seconds since
// 1970-01-01 00:00:00. The zone bias register (12-bit signed minutes) is
// written by cfg_we_i/cfg_wdata_i; the user must write it only while the
// block is idle, and the block itself does not enforce this. 60 times its
// value is subtracted from each item, wrapping modulo 2^32. Output channel
// out_o carries one item per input item: year since 1900, month 1-12, day
// of month, hour, minute and second.
//
// One item is worked on at a time. The serial divider makes the day split,
// then the splits for seconds and minutes; the year/month walk runs beside
// the last two splits, stepping through four-year blocks, single years and
// months, and late in the range it can outlast them and delay the output
// load. The next item can be accepted in the cycle after the output load.
// A finished item waits in the output register while out_o.ready is low;
// the next item is accepted meanwhile and holds before its output load.
// Reset clears the bias to zero and drops any item in flight.
// Depends on ets_pkg, ets_stream_if, ets_serdiv and ets_calwalk.
`default_nettype none

module epoch_seconds_to_calendar import ets_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic signed [BiasW-1:0] cfg_wdata_i,
  ets_in_if.sink                       in_i,
  ets_out_if.source                    out_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DAY  = 5'b00010,
    ST_SEC  = 5'b00100,
    ST_MIN  = 5'b01000,
    ST_WAIT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [EpochW-1:0] bias60_q, bias_ext;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  cal_req_t          cal_req;
  cal_rsp_t          cal_rsp;

  logic [HourW-1:0]  hour_q;
  logic [MinW-1:0]   min_q;
  logic [SecW-1:0]   sec_q;
  logic              out_valid_q;
  logic [YearW-1:0]  out_year_q;
  logic [MonthW-1:0] out_month_q;
  logic [DayW-1:0]   out_day_q;
  logic [HourW-1:0]  out_hour_q;
  logic [MinW-1:0]   out_min_q;
  logic [SecW-1:0]   out_sec_q;
  logic              in_acc, out_load;

  // Keep the bias pre-scaled to seconds: 60b = 64b - 4b
  assign bias_ext = {{(EpochW-BiasW){cfg_wdata_i[BiasW-1]}}, cfg_wdata_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias60_q <= '0;
    end else if (cfg_we_i) begin
      bias60_q <= (bias_ext << 6) - (bias_ext << 2);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_WAIT) && cal_rsp.valid && (!out_valid_q || out_o.ready);

  // Sequence the three divisions and the output load
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = SecPerDay;
    div_req.steps    = StepW'(EpochW);
    cal_req.start    = 1'b0;
    cal_req.days     = div_rsp.quotient[DaysW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          div_req.start    = 1'b1;
          div_req.dividend = in_i.epoch_seconds - bias60_q;
          state_d          = ST_DAY;
        end
      end
      ST_DAY: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {div_rsp.remainder, (EpochW-RemW)'(0)};
          div_req.divisor  = SecPerMin;
          div_req.steps    = StepW'(RemW);
          cal_req.start    = 1'b1;
          state_d          = ST_SEC;
        end
      end
      ST_SEC: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {div_rsp.quotient[MinDayW-1:0], (EpochW-MinDayW)'(0)};
          div_req.divisor  = MinPerHr;
          div_req.steps    = StepW'(MinDayW);
          state_d          = ST_MIN;
        end
      end
      ST_MIN: begin
        if (div_rsp.done) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  ets_serdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ets_calwalk u_cal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cal_req),
    .rsp_o  (cal_rsp)
  );

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture time of day from the divider, then the output item
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SEC) && div_rsp.done) begin
      sec_q <= div_rsp.remainder[SecW-1:0];
    end
    if ((state_q == ST_MIN) && div_rsp.done) begin
      min_q  <= div_rsp.remainder[MinW-1:0];
      hour_q <= div_rsp.quotient[HourW-1:0];
    end
    if (out_load) begin
      out_year_q  <= cal_rsp.year;
      out_month_q <= cal_rsp.month;
      out_day_q   <= cal_rsp.day;
      out_hour_q  <= hour_q;
      out_min_q   <= min_q;
      out_sec_q   <= sec_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.year_since_1900  = out_year_q;
  assign out_o.month_number     = out_month_q;
  assign out_o.day_of_month     = out_day_q;
  assign out_o.hour_of_day      = out_hour_q;
  assign out_o.minute_of_hour   = out_min_q;
  assign out_o.second_of_minute = out_sec_q;

  // An accepted item blocks the input until its result is loaded
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input accepted while an item is in flight");

  // Divider completes only while the sequencer waits for it
  a_div_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DAY || state_q == ST_SEC || state_q == ST_MIN))
    else $error("divider completion outside a division step");

  // Delivered time of day and date fields stay in range
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.hour_of_day < HourW'(24) && out_o.minute_of_hour < MinW'(60)
                     && out_o.second_of_minute < SecW'(60)
                     && out_o.month_number != MonthW'(0) && out_o.month_number < MonthW'(13)
                     && out_o.day_of_month != DayW'(0)))
    else $error("output field out of range");

  // A waiting output item holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.day_of_month)
                                       && $stable(out_o.second_of_minute)))
    else $error("output item changed while stalled");

endmodule

`default_nettype wire

FILE: tb/tb_epoch_seconds_to_calendar.sv
// Self-checking bench for epoch_seconds_to_calendar: a scoreboard predicts the
// date and time of each accepted item, plain tasks drive the input channel.
// Depends on ets_pkg, ets_stream_if and the epoch_seconds_to_calendar RTL.
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar;
  import ets_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned DrainWait  = 120;

  // Day offsets within a year that sit on month and leap-day edges
  localparam int DayMarks [6] = '{0, 58, 59, 60, 364, 365};

  // Plain counts under the reset bias: day, year and leap-day edges, top of range
  localparam logic [EpochW-1:0] PlainMarks [14] = '{
    32'd0, 32'd86399, 32'd86400, 32'd31535999, 32'd68169600, 32'd951782400,
    32'd978307199, 32'd4107542399, 32'd4107542400, 32'h7FFF_FFFF,
    32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } calendar_t;

  class calendar_scoreboard;
    logic signed [BiasW-1:0] zone_bias = '0;
    calendar_t               expected_dates [$];
    int unsigned             mismatches = 0;
    int unsigned             checked = 0;

    function bit is_leap(int unsigned yr);
      return ((yr % 400) == 0) || (((yr % 100) != 0) && ((yr % 4) == 0));
    endfunction

    function string show(calendar_t c);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d", int'(c.year) + 1900, c.month,
                       c.day, c.hour, c.minute, c.second);
    endfunction

    // Apply the bias, split off time of day, then walk years and months
    function calendar_t to_calendar(logic [EpochW-1:0] epoch);
      calendar_t   cal;
      logic [31:0] t;
      int unsigned days, yr, mon, ylen, mlen;
      int unsigned common_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      t = epoch - 32'(60 * int'(zone_bias));
      cal.second = SecW'(t % 60);
      t = t / 60;
      cal.minute = MinW'(t % 60);
      t = t / 60;
      cal.hour = HourW'(t % 24);
      days = t / 24;
      yr = 1970;
      ylen = is_leap(yr) ? 366 : 365;
      while (days >= ylen) begin
        days -= ylen;
        yr++;
        ylen = is_leap(yr) ? 366 : 365;
      end
      mon = 0;
      while (mon < 11) begin
        mlen = common_len[mon];
        if (mon == 1 && is_leap(yr)) mlen = 29;
        if (days < mlen) break;
        days -= mlen;
        mon++;
      end
      cal.year  = YearW'(yr - 1900);
      cal.month = MonthW'(mon + 1);
      cal.day   = DayW'(days + 1);
      return cal;
    endfunction

    function void note_item(logic [EpochW-1:0] epoch);
      expected_dates.push_back(to_calendar(epoch));
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      checked++;
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result %s", $time, show(got));
        return;
      end
      want = expected_dates.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute ||
          got.second !== want.second) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: date mismatch, expected %s, got %s", $time, show(want),
                   show(got));
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic signed [BiasW-1:0] cfg_wdata_i = '0;
  bit                      idle_en = 1'b1;
  int unsigned             sink_hold = 0;
  int unsigned             stall_cycles = 0;
  int unsigned             items_sent = 0;
  int unsigned             bias_settings = 1;
  calendar_scoreboard      sb;

  ets_in_if  in_if ();
  ets_out_if out_if ();

  epoch_seconds_to_calendar dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_i (in_if),
    .out_o(out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the result side in random bursts while idling is enabled
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
      out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      sink_hold = $urandom_range(0, 13);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Check accepted results and count cycles with no progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result('{out_if.year_since_1900, out_if.month_number,
                          out_if.day_of_month, out_if.hour_of_day,
                          out_if.minute_of_hour, out_if.second_of_minute});
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
             StallLimit, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Present one item, with an optional gap first, and hold it until taken
  task automatic send_epoch(logic [EpochW-1:0] epoch);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.epoch_seconds <= epoch;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(epoch);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the zone bias while the block is idle
  task automatic write_bias(logic signed [BiasW-1:0] bias);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= bias;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.zone_bias = bias;
    bias_settings++;
  endtask

  initial begin
    logic signed [BiasW-1:0] bias;
    longint                  skew, value;
    int unsigned             yr, ly;
    sb = new();
    in_if.valid = 1'b0;
    in_if.epoch_seconds = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: edges under the reset bias, then both wrap ends of the subtraction
    foreach (PlainMarks[i]) send_epoch(PlainMarks[i]);
    hold_until_drained();
    write_bias(12'sd2047);
    send_epoch(32'd0);
    send_epoch(32'd122820);
    send_epoch(32'd122819);
    hold_until_drained();
    write_bias(-12'sd2048);
    send_epoch(32'hFFFF_FFFF);
    send_epoch(32'd4294844416);
    send_epoch(32'd4294844415);
    hold_until_drained();
    write_bias(12'sd1440);
    send_epoch(32'd86400);
    send_epoch(32'd86399);
    hold_until_drained();
    write_bias(-12'sd1440);
    send_epoch(32'd0);
    send_epoch(32'hFFFF_FFFF);

    // Random phases, one bias setting each; every third phase and the last run with no idling
    for (int p = 0; p < NumPhases; p++) begin
      hold_until_drained();
      case (p)
        0: bias = 12'sd0;
        1: bias = 12'sd1440;
        2: bias = -12'sd1440;
        3: bias = 12'sd2047;
        4: bias = -12'sd2048;
        5: bias = -12'sd1;
        6: bias = BiasW'(int'($urandom_range(0, 2880)) - 1440);
        default: bias = BiasW'($urandom);
      endcase
      write_bias(bias);
      idle_en = (p == NumPhases - 1) ? 1'b0 : ((p % 3) != 2);
      skew = 60 * longint'(bias);
      for (int n = 0; n < PhaseItems; n++) begin
        yr = $urandom_range(1970, 2106);
        ly = yr - 1;
        case ($urandom_range(0, 9))
          4, 5, 6: begin
            // Land on a year, month or leap-day edge after the bias
            value = longint'(yr - 1970) * 365 + ly / 4 - ly / 100 + ly / 400
                    - (1969 / 4 - 1969 / 100 + 1969 / 400);
            value = (value + DayMarks[$urandom_range(0, 5)]) * 86400
                    + int'($urandom_range(0, 4)) - 2 + skew;
          end
          7: value = 64'hFFFF_FFFF - $urandom_range(0, 200000) + skew;
          8: value = $urandom_range(0, 200000) + skew;
          9: value = longint'($urandom_range(0, 49710)) * 86400
                     + int'($urandom_range(0, 4)) - 2 + skew;
          default: value = $urandom;
        endcase
        send_epoch(EpochW'(value));
        // Now and then let the block run dry mid-phase
        if ($urandom_range(0, 299) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (DrainWait) @(posedge clk_i);
    $display("Converted %0d items under %0d zone bias settings, from -2048 to 2047.",
             items_sent, bias_settings);
    $display("Stimulus mixed full-range counts, year and leap-day edges and both wrap ends.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: epoch_seconds_to_calendar.f
rtl/ets_pkg.sv
rtl/ets_stream_if.sv
rtl/ets_serdiv.sv
rtl/ets_calwalk.sv
rtl/epoch_seconds_to_calendar.sv
tb/tb_epoch_seconds_to_calendar.sv
